### src/v3alu_pkg.sv
`timescale 1ns / 1ps
// Shared opcodes, pipeline depths and stage payload types for the vector ALU.
package v3alu_pkg;

   // Opcodes
   localparam logic [3:0] OP_ADD       = 4'd0;
   localparam logic [3:0] OP_SUB       = 4'd1;
   localparam logic [3:0] OP_DOT       = 4'd2;
   localparam logic [3:0] OP_SCALE     = 4'd3;
   localparam logic [3:0] OP_DIVIDE    = 4'd4;
   localparam logic [3:0] OP_LENGTH    = 4'd5;
   localparam logic [3:0] OP_NORMALIZE = 4'd6;
   localparam logic [3:0] OP_EQUAL     = 4'd7;
   localparam logic [3:0] OP_CROSS     = 4'd8;

   // Tolerance after reset, about 0.3 in Q16.16
   localparam logic [30:0] TOL_RESET = 31'd19661;

   // Square root: one result bit per stage over a 64-bit radicand
   localparam int SQRT_STEPS = 32;
   // Divider: quotient and divisor widths, one quotient bit per stage
   localparam int QW         = 48;
   localparam int DW         = 33;
   localparam int DIV_STEPS  = QW;

   typedef logic signed [31:0] q16_type;

   // Payload riding alongside the square-root pipeline
   typedef struct packed {
      logic [3:0] op;
      q16_type    a_x;
      q16_type    a_y;
      q16_type    a_z;
      q16_type    scl;
      q16_type    f_x;
      q16_type    f_y;
      q16_type    f_z;
      q16_type    f_s;
      logic       eq;
   } sq_side_type;

   // Payload riding alongside the divider pipeline
   typedef struct packed {
      logic [3:0] op;
      q16_type    f_x;
      q16_type    f_y;
      q16_type    f_z;
      q16_type    f_s;
      logic       eq;
      logic       flt;
      logic [2:0] neg;
   } div_side_type;

endpackage

### src/vector3_fixed_point_alu.sv
`timescale 1ns / 1ps
// Pipelined Q16.16 3D vector ALU: add, sub, dot, scale, divide, length, normalize, equal, cross.
//
// Input channel req_*: a transaction carries an opcode, vectors A and B and a scalar.
// It is taken at a rising edge with req_valid high and req_stall low.
// Result channel rsp_*: one result transaction per input, in order, taken at a
// rising edge with rsp_valid high and rsp_stall low.
// csr_wr_en/csr_wr_data write the equality tolerance (Q16.16); write it only
// while no transaction is in flight.
//
// Every opcode passes through the same steps in order: multiply, product sum, saturation,
// a 32-stage square-root pipeline, length rounding, divider setup, a 48-stage
// restoring divider (one quotient bit per stage) and the output register.
// Throughput is one transaction per cycle while no result is held under rsp_stall.
//
// Synchronous reset empties the pipeline and loads the default tolerance.
// While a result waits under rsp_stall the whole pipeline holds and req_stall
// is raised; nothing is dropped or repeated.
module vector3_fixed_point_alu (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [30:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic signed [31:0] req_scalar_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_res_x,
   output logic signed [31:0] rsp_res_y,
   output logic signed [31:0] rsp_res_z,
   output logic signed [31:0] rsp_res_scalar,
   output logic               rsp_is_equal,
   output logic               rsp_fault
);
   import v3alu_pkg::*;

   // Saturate a sign-extended 50-bit value to 32 bits
   function automatic logic [31:0] sat_wide(input logic [49:0] v);
      if (v[49:31] == '0 || v[49:31] == '1) return v[31:0];
      return v[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   // Apply sign to an unsigned quotient and saturate
   function automatic logic [31:0] sat_quot(input logic [QW-1:0] q, input logic neg);
      logic [QW-1:0] nq;
      nq = ~q + {{(QW-1){1'b0}}, 1'b1};
      if (!neg) return (q[QW-1:31] != '0) ? 32'h7FFF_FFFF : q[31:0];
      if (q > {{(QW-32){1'b0}}, 32'h8000_0000}) return 32'h8000_0000;
      return nq[31:0];
   endfunction

   // Global advance: the pipeline moves unless a finished result is stalled
   logic adv;
   logic rsp_valid_ff, rsp_valid_in;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Tolerance register
   logic [30:0] tol_ff, tol_in;
   assign tol_in = csr_wr_en ? csr_wr_data : tol_ff;
   always_ff @(posedge clock) begin
      if (reset) tol_ff <= TOL_RESET;
      else       tol_ff <= tol_in;
   end

   // ---------------- Stage 1: multipliers, add/sub, equality ----------------
   logic signed [31:0] ma [3];
   logic signed [31:0] mb [3];
   logic signed [31:0] av [3];
   logic signed [31:0] bv [3];
   logic signed [63:0] m_in [6];
   logic signed [63:0] m_ff [6];
   sq_side_type        side1_in, side1_ff;
   logic               v1_ff;

   always_comb begin
      logic [32:0] sum33;
      logic [32:0] dif33;
      logic [32:0] adif;
      logic        all_eq;
      av = '{req_a_x, req_a_y, req_a_z};
      bv = '{req_b_x, req_b_y, req_b_z};
      ma = av;
      mb = av;
      unique case (req_opcode)
         OP_DOT:   mb = bv;
         OP_SCALE: mb = '{req_scalar_in, req_scalar_in, req_scalar_in};
         OP_CROSS: begin
            ma = '{req_a_y, req_a_z, req_a_x};
            mb = '{req_b_z, req_b_x, req_b_y};
         end
         default:  mb = av;
      endcase
      for (int i = 0; i < 3; i++) m_in[i] = ma[i] * mb[i];
      m_in[3] = req_a_z * req_b_y;
      m_in[4] = req_a_x * req_b_z;
      m_in[5] = req_a_y * req_b_x;

      side1_in     = '0;
      side1_in.op  = req_opcode;
      side1_in.a_x = req_a_x;
      side1_in.a_y = req_a_y;
      side1_in.a_z = req_a_z;
      side1_in.scl = req_scalar_in;
      all_eq       = 1'b1;
      for (int i = 0; i < 3; i++) begin
         sum33 = {av[i][31], av[i]} + {bv[i][31], bv[i]};
         dif33 = {av[i][31], av[i]} - {bv[i][31], bv[i]};
         adif  = dif33[32] ? (~dif33 + 33'd1) : dif33;
         if (adif > {2'b00, tol_ff}) all_eq = 1'b0;
         if (req_opcode == OP_ADD || req_opcode == OP_SUB) begin
            if (i == 0) side1_in.f_x = (req_opcode == OP_ADD) ?
                                       sat_wide({{17{sum33[32]}}, sum33}) :
                                       sat_wide({{17{dif33[32]}}, dif33});
            if (i == 1) side1_in.f_y = (req_opcode == OP_ADD) ?
                                       sat_wide({{17{sum33[32]}}, sum33}) :
                                       sat_wide({{17{dif33[32]}}, dif33});
            if (i == 2) side1_in.f_z = (req_opcode == OP_ADD) ?
                                       sat_wide({{17{sum33[32]}}, sum33}) :
                                       sat_wide({{17{dif33[32]}}, dif33});
         end
      end
      side1_in.eq = (req_opcode == OP_EQUAL) && all_eq;
   end

   always_ff @(posedge clock) begin
      if (reset)    v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff     <= m_in;
         side1_ff <= side1_in;
      end
   end

   // ---------------- Stage 2: product sums with rounding offset -------------
   logic signed [65:0] t_in [3];
   logic signed [65:0] t_ff [3];
   logic signed [65:0] dot_in, dot_ff;
   logic [63:0]        sq_in, sq_ff;
   sq_side_type        side2_ff;
   logic               v2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_in[i] = {{2{m_ff[i][63]}}, m_ff[i]} + 66'sd32768;
         if (side1_ff.op == OP_CROSS)
            t_in[i] = t_in[i] - {{2{m_ff[i+3][63]}}, m_ff[i+3]};
      end
      dot_in = {{2{m_ff[0][63]}}, m_ff[0]} + {{2{m_ff[1][63]}}, m_ff[1]}
             + {{2{m_ff[2][63]}}, m_ff[2]} + 66'sd32768;
      sq_in  = m_ff[0] + m_ff[1] + m_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset)    v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff     <= t_in;
         dot_ff   <= dot_in;
         sq_ff    <= sq_in;
         side2_ff <= side1_ff;
      end
   end

   // ---------------- Stage 3: saturate products, load square root -----------
   logic [63:0] sqx_ff [SQRT_STEPS+1];
   logic [63:0] sqr_ff [SQRT_STEPS+1];
   sq_side_type sside_ff [SQRT_STEPS+1];
   logic        sv_ff [SQRT_STEPS+1];
   sq_side_type side3_in;

   always_comb begin
      side3_in = side2_ff;
      if (side2_ff.op == OP_SCALE || side2_ff.op == OP_CROSS) begin
         side3_in.f_x = sat_wide(t_ff[0][65:16]);
         side3_in.f_y = sat_wide(t_ff[1][65:16]);
         side3_in.f_z = sat_wide(t_ff[2][65:16]);
      end
      if (side2_ff.op == OP_DOT) side3_in.f_s = sat_wide(dot_ff[65:16]);
   end

   always_ff @(posedge clock) begin
      if (reset)    sv_ff[0] <= 1'b0;
      else if (adv) sv_ff[0] <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff[0]   <= sq_ff;
         sqr_ff[0]   <= '0;
         sside_ff[0] <= side3_in;
      end
   end

   // ---------------- Square-root pipeline, one root bit per stage -----------
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] x_in, r_in;

      always_comb begin
         logic [63:0] trial;
         trial = sqr_ff[k] + BIT;
         if (sqx_ff[k] >= trial) begin
            x_in = sqx_ff[k] - trial;
            r_in = (sqr_ff[k] >> 1) + BIT;
         end else begin
            x_in = sqx_ff[k];
            r_in = sqr_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset)    sv_ff[k+1] <= 1'b0;
         else if (adv) sv_ff[k+1] <= sv_ff[k];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sqx_ff[k+1]   <= x_in;
            sqr_ff[k+1]   <= r_in;
            sside_ff[k+1] <= sside_ff[k];
         end
      end
   end

   // ---------------- Length rounding ----------------------------------------
   logic [DW-1:0] len_in, len_ff;
   sq_side_type   lside_ff;
   logic          lv_ff;

   assign len_in = {1'b0, sqr_ff[SQRT_STEPS][31:0]}
                 + {{(DW-1){1'b0}}, (sqx_ff[SQRT_STEPS] > sqr_ff[SQRT_STEPS])};

   always_ff @(posedge clock) begin
      if (reset)    lv_ff <= 1'b0;
      else if (adv) lv_ff <= sv_ff[SQRT_STEPS];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         len_ff   <= len_in;
         lside_ff <= sside_ff[SQRT_STEPS];
      end
   end

   // ---------------- Divider setup ------------------------------------------
   logic [DW-1:0] d_ff   [DIV_STEPS+1];
   logic [DW-1:0] rem_ff [DIV_STEPS+1][3];
   logic [QW-1:0] nq_ff  [DIV_STEPS+1][3];
   div_side_type  dside_ff [DIV_STEPS+1];
   logic          dv_ff  [DIV_STEPS+1];
   logic [DW-1:0] d0_in;
   logic [QW-1:0] n0_in [3];
   div_side_type  dside0_in;

   always_comb begin
      logic [31:0] aabs [3];
      logic [31:0] sabs;
      logic [31:0] asgn [3];
      asgn = '{lside_ff.a_x, lside_ff.a_y, lside_ff.a_z};
      for (int i = 0; i < 3; i++)
         aabs[i] = asgn[i][31] ? (~asgn[i] + 32'd1) : asgn[i];
      sabs = lside_ff.scl[31] ? (~lside_ff.scl + 32'd1) : lside_ff.scl;
      d0_in = (lside_ff.op == OP_DIVIDE) ? {1'b0, sabs} : len_ff;
      for (int i = 0; i < 3; i++)
         n0_in[i] = {aabs[i], 16'd0} + {{(QW-DW+1){1'b0}}, d0_in[DW-1:1]};

      dside0_in     = '0;
      dside0_in.op  = lside_ff.op;
      dside0_in.f_x = lside_ff.f_x;
      dside0_in.f_y = lside_ff.f_y;
      dside0_in.f_z = lside_ff.f_z;
      dside0_in.f_s = lside_ff.f_s;
      dside0_in.eq  = lside_ff.eq;
      if (lside_ff.op == OP_LENGTH)
         dside0_in.f_s = (len_ff[DW-1:31] != '0) ? 32'h7FFF_FFFF : len_ff[31:0];
      for (int i = 0; i < 3; i++)
         dside0_in.neg[2-i] = asgn[i][31] ^
                              ((lside_ff.op == OP_DIVIDE) && lside_ff.scl[31]);
      dside0_in.flt = ((lside_ff.op == OP_DIVIDE) || (lside_ff.op == OP_NORMALIZE))
                      && (d0_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset)    dv_ff[0] <= 1'b0;
      else if (adv) dv_ff[0] <= lv_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0]     <= d0_in;
         dside_ff[0] <= dside0_in;
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= '0;
            nq_ff[0][i]  <= n0_in[i];
         end
      end
   end

   // ---------------- Restoring divider, one quotient bit per stage ----------
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [DW-1:0] rem_in [3];
      logic [QW-1:0] nq_in  [3];

      always_comb begin
         logic [DW:0] trial;
         logic [DW:0] diff;
         logic        ge;
         for (int i = 0; i < 3; i++) begin
            trial     = {rem_ff[k][i], nq_ff[k][i][QW-1]};
            diff      = trial - {1'b0, d_ff[k]};
            ge        = (trial >= {1'b0, d_ff[k]});
            rem_in[i] = ge ? diff[DW-1:0] : trial[DW-1:0];
            nq_in[i]  = {nq_ff[k][i][QW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset)    dv_ff[k+1] <= 1'b0;
         else if (adv) dv_ff[k+1] <= dv_ff[k];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            d_ff[k+1]     <= d_ff[k];
            dside_ff[k+1] <= dside_ff[k];
            rem_ff[k+1]   <= rem_in;
            nq_ff[k+1]    <= nq_in;
         end
      end
   end

   // ---------------- Output register ----------------------------------------
   logic [31:0] res_x_ff, res_y_ff, res_z_ff, res_s_ff;
   logic [31:0] res_x_in, res_y_in, res_z_in, res_s_in;
   logic        eq_ff, eq_in, flt_ff, flt_in;
   div_side_type dlast;

   assign dlast = dside_ff[DIV_STEPS];

   always_comb begin
      res_x_in = dlast.f_x;
      res_y_in = dlast.f_y;
      res_z_in = dlast.f_z;
      res_s_in = dlast.f_s;
      eq_in    = dlast.eq;
      flt_in   = dlast.flt;
      if (dlast.op == OP_DIVIDE || dlast.op == OP_NORMALIZE) begin
         if (dlast.flt) begin
            res_x_in = '0;
            res_y_in = '0;
            res_z_in = '0;
         end else begin
            res_x_in = sat_quot(nq_ff[DIV_STEPS][0], dlast.neg[2]);
            res_y_in = sat_quot(nq_ff[DIV_STEPS][1], dlast.neg[1]);
            res_z_in = sat_quot(nq_ff[DIV_STEPS][2], dlast.neg[0]);
         end
      end
   end

   assign rsp_valid_in = dv_ff[DIV_STEPS];
   always_ff @(posedge clock) begin
      if (reset)    rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= rsp_valid_in;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         res_x_ff <= res_x_in;
         res_y_ff <= res_y_in;
         res_z_ff <= res_z_in;
         res_s_ff <= res_s_in;
         eq_ff    <= eq_in;
         flt_ff   <= flt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_res_x      = res_x_ff;
   assign rsp_res_y      = res_y_ff;
   assign rsp_res_z      = res_z_ff;
   assign rsp_res_scalar = res_s_ff;
   assign rsp_is_equal   = eq_ff;
   assign rsp_fault      = flt_ff;

   // ---------------- Assertions ---------------------------------------------
   // Reset empties the output stage
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A faulted result carries only zeros
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_res_x == '0 && rsp_res_y == '0 &&
                                 rsp_res_z == '0 && rsp_res_scalar == '0 && !rsp_is_equal)
      else $error("fault result with nonzero fields");

   // An equality result carries no vector, scalar or fault
   a_equal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_equal |-> !rsp_fault && rsp_res_x == '0 &&
                                    rsp_res_y == '0 && rsp_res_z == '0 &&
                                    rsp_res_scalar == '0)
      else $error("equal flag with other fields set");

endmodule
